>>> hdl/assert_macros.svh
// Assertion helpers for the polling master.
// Both macros sample on the rising edge of clk and are switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property in the same cycle.
`define PMDR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another condition in the next cycle.
`define PMDR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/pmdr_pkg.sv
package pmdr_pkg;

  // Default node capacity, and the reset values of the registers.
  localparam int MaxNodesDefault = 8;

  localparam logic [15:0] RoundIntervalRst   = 16'd1000;
  localparam logic [15:0] ResponseTimeoutRst = 16'd750;
  localparam logic [15:0] InterPollGuardRst  = 16'd25;
  localparam logic [15:0] RetryGuardRst      = 16'd75;
  localparam logic [3:0]  NodeCountRst       = 4'd3;
  localparam logic [15:0] ExpectedKindsRst   = 16'd37;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ROUND_INTERVAL   = 3'd0;
  localparam logic [2:0] REG_RESPONSE_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_INTER_POLL_GUARD = 3'd2;
  localparam logic [2:0] REG_RETRY_GUARD      = 3'd3;
  localparam logic [2:0] REG_NODE_COUNT       = 3'd4;
  localparam logic [2:0] REG_EXPECTED_KINDS   = 3'd5;

  // Event kinds on the input channel.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_TX   = 2'd1;
  localparam logic [1:0] REQ_PKT  = 2'd2;

  // Result codes.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_POLL = 2'd1;
  localparam logic [1:0] ACT_ACK  = 2'd2;

  localparam logic [2:0] PST_NONE      = 3'd0;
  localparam logic [2:0] PST_NEW       = 3'd1;
  localparam logic [2:0] PST_DUP       = 3'd2;
  localparam logic [2:0] PST_MALFORMED = 3'd3;
  localparam logic [2:0] PST_UNKNOWN   = 3'd4;

  localparam logic [1:0] OUT_NONE     = 2'd0;
  localparam logic [1:0] OUT_ANSWERED = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT  = 2'd2;
  localparam logic [1:0] OUT_TX_FAIL  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_TX,
    PH_WAIT_RESP,
    PH_GUARD,
    PH_RETRY_GUARD
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  target_node;
    logic        is_retry;
    logic [31:0] ack_seq;
    logic [2:0]  packet_status;
    logic [1:0]  poll_outcome;
    logic        round_done;
  } result_t;

endpackage

>>> hdl/polling_master_with_deferred_retry.sv
// Polling master of a radio hub with a deferred retry pass.
// Input channel (in_*): one item per event. in_tuser carries the event kind
// (tick, poll transmit result, received packet), in_tdata the packet fields.
// Result channel (out_*): exactly one item per input item, in order. out_tuser
// carries the action (none, poll, acknowledge), out_tdata the remaining fields.
// Configuration port (cfg_*): a register is written at any clock edge with
// cfg_we high; writes are expected only while no item is in flight.
// The result of an item accepted at one edge is shown in out_tvalid/out_tdata
// after that edge. Throughput is one item per cycle unless the receiver stalls;
// all the work for an item is a single pass of compare and increment logic on
// small registers between the input handshake and the result register.
// Reset (rst_n low, synchronous) loads the register defaults, forgets all
// sequence history and arms the first round, which starts on the first tick.
// When the receiver stalls, the result register holds its item and in_tready
// stays high only if that item leaves in the same cycle, so no result is lost.
`include "assert_macros.svh"

module polling_master_with_deferred_retry #(
  parameter int MAX_NODES = pmdr_pkg::MaxNodesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: tx_ok, pkt_format_ok, pkt_known, pkt_node[2:0],
  // pkt_kind[1:0], pkt_seq[31:0].
  input  logic [39:0] in_tdata,
  // Fields from bit 0 up: req_type[1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: target_node[2:0], is_retry, ack_seq[31:0],
  // packet_status[2:0], poll_outcome[1:0], round_done, then zero padding.
  output logic [47:0] out_tdata,
  // Fields from bit 0 up: action[1:0].
  output logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  // Configuration registers.
  logic [15:0] round_interval_r, response_timeout_r, inter_poll_guard_r, retry_guard_r;
  logic [3:0]  node_count_r;
  logic [15:0] expected_kinds_r;

  // Round state.
  pmdr_pkg::phase_t       phase_r, phase_nxt;
  logic [2:0]             current_index_r, current_index_nxt;
  logic                   retry_pass_r, retry_pass_nxt;
  logic [MAX_NODES-1:0]   missed_map_r, missed_map_nxt;
  logic [15:0]            wait_timer_r, wait_timer_nxt;
  logic [15:0]            round_timer_r, round_timer_nxt;
  logic                   first_pending_r, first_pending_nxt;

  // Per-node sequence history. The sequence store is only read behind the
  // node's seen flag, so it needs no reset.
  logic [MAX_NODES-1:0]   seen_r, seen_nxt;
  logic [31:0]            last_seq_r [MAX_NODES];
  logic                   seq_we;

  // Result register.
  logic                   out_valid_r;
  pmdr_pkg::result_t      out_res_r;
  pmdr_pkg::result_t      res;

  // Unpacked input fields.
  logic        in_accept;
  logic [1:0]  req_type;
  logic        tx_ok, pkt_format_ok, pkt_known;
  logic [2:0]  pkt_node;
  logic [1:0]  pkt_kind;
  logic [31:0] pkt_seq;
  logic [IDX_W-1:0] node_idx;

  assign req_type      = in_tuser;
  assign tx_ok         = in_tdata[0];
  assign pkt_format_ok = in_tdata[1];
  assign pkt_known     = in_tdata[2];
  assign pkt_node      = in_tdata[5:3];
  assign pkt_kind      = in_tdata[7:6];
  assign pkt_seq       = in_tdata[39:8];
  assign node_idx      = pkt_node[IDX_W-1:0];

  // A new item can enter whenever the result register is empty or drains now.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {6'd0, out_res_r.round_done, out_res_r.poll_outcome,
                       out_res_r.packet_status, out_res_r.ack_seq,
                       out_res_r.is_retry, out_res_r.target_node};

  // Effective node count: zero counts as one, anything above capacity is capped.
  logic [3:0]           count;
  logic [MAX_NODES-1:0] count_mask;

  always_comb begin
    if (node_count_r == 4'd0) begin
      count = 4'd1;
    end else if (node_count_r > 4'(MAX_NODES)) begin
      count = 4'(MAX_NODES);
    end else begin
      count = node_count_r;
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      count_mask[i] = (4'(i) < count);
    end
  end

  // First missed node at or after start and below the node count; returns
  // the node count when there is none.
  function automatic logic [3:0] next_missed(input logic [MAX_NODES-1:0] map,
                                             input logic [3:0] start,
                                             input logic [3:0] cnt);
    logic [3:0] found;
    found = cnt;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (map[i] && (4'(i) >= start) && (4'(i) < cnt)) begin
        found = 4'(i);
      end
    end
    return found;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_interval_r   <= pmdr_pkg::RoundIntervalRst;
      response_timeout_r <= pmdr_pkg::ResponseTimeoutRst;
      inter_poll_guard_r <= pmdr_pkg::InterPollGuardRst;
      retry_guard_r      <= pmdr_pkg::RetryGuardRst;
      node_count_r       <= pmdr_pkg::NodeCountRst;
      expected_kinds_r   <= pmdr_pkg::ExpectedKindsRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pmdr_pkg::REG_ROUND_INTERVAL:   round_interval_r   <= cfg_wdata;
        pmdr_pkg::REG_RESPONSE_TIMEOUT: response_timeout_r <= cfg_wdata;
        pmdr_pkg::REG_INTER_POLL_GUARD: inter_poll_guard_r <= cfg_wdata;
        pmdr_pkg::REG_RETRY_GUARD:      retry_guard_r      <= cfg_wdata;
        pmdr_pkg::REG_NODE_COUNT:       node_count_r       <= cfg_wdata[3:0];
        pmdr_pkg::REG_EXPECTED_KINDS:   expected_kinds_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Event processing: next state and the result of the accepted item.
  logic [15:0] rt_inc, wt_inc, kinds_shift;
  logic [3:0]  nxt_idx, miss_idx;
  logic        do_poll, poll_retry, do_end, do_fail;
  logic [3:0]  poll_idx;
  logic [1:0]  fail_code, exp_kind;
  logic        dup;

  always_comb begin
    phase_nxt         = phase_r;
    current_index_nxt = current_index_r;
    retry_pass_nxt    = retry_pass_r;
    missed_map_nxt    = missed_map_r;
    wait_timer_nxt    = wait_timer_r;
    round_timer_nxt   = round_timer_r;
    first_pending_nxt = first_pending_r;
    seen_nxt          = seen_r;
    seq_we            = 1'b0;
    res               = '0;

    do_poll    = 1'b0;
    poll_idx   = 4'd0;
    poll_retry = 1'b0;
    do_end     = 1'b0;
    do_fail    = 1'b0;
    fail_code  = pmdr_pkg::OUT_NONE;

    rt_inc      = (round_timer_r == 16'hFFFF) ? round_timer_r : round_timer_r + 16'd1;
    wt_inc      = wait_timer_r + 16'd1;
    nxt_idx     = {1'b0, current_index_r} + 4'd1;
    miss_idx    = next_missed(missed_map_r,
                              (phase_r == pmdr_pkg::PH_RETRY_GUARD) ? 4'd0 : nxt_idx,
                              count);
    kinds_shift = expected_kinds_r >> {pkt_node, 1'b0};
    exp_kind    = kinds_shift[1:0];
    dup         = seen_r[node_idx] && (last_seq_r[node_idx] == pkt_seq);

    if (in_accept) begin
      case (req_type)
        pmdr_pkg::REQ_TICK: begin
          round_timer_nxt = rt_inc;
          unique case (phase_r)
            pmdr_pkg::PH_IDLE: begin
              if (first_pending_r || (rt_inc >= round_interval_r)) begin
                first_pending_nxt = 1'b0;
                round_timer_nxt   = 16'd0;
                retry_pass_nxt    = 1'b0;
                missed_map_nxt    = '0;
                do_poll           = 1'b1;
                poll_idx          = 4'd0;
              end
            end
            pmdr_pkg::PH_WAIT_RESP: begin
              wait_timer_nxt = wt_inc;
              if (wt_inc >= response_timeout_r) begin
                do_fail   = 1'b1;
                fail_code = pmdr_pkg::OUT_TIMEOUT;
              end
            end
            pmdr_pkg::PH_GUARD: begin
              if (wait_timer_r >= inter_poll_guard_r) begin
                // Guard over: next node, the retry pass, or the end of the round.
                if (!retry_pass_r) begin
                  if (nxt_idx < count) begin
                    do_poll  = 1'b1;
                    poll_idx = nxt_idx;
                  end else if ((missed_map_r & count_mask) != '0) begin
                    retry_pass_nxt = 1'b1;
                    phase_nxt      = pmdr_pkg::PH_RETRY_GUARD;
                    wait_timer_nxt = 16'd0;
                  end else begin
                    do_end = 1'b1;
                  end
                end else if (miss_idx < count) begin
                  do_poll    = 1'b1;
                  poll_idx   = miss_idx;
                  poll_retry = 1'b1;
                end else begin
                  do_end = 1'b1;
                end
              end else begin
                wait_timer_nxt = wt_inc;
              end
            end
            pmdr_pkg::PH_RETRY_GUARD: begin
              if (wait_timer_r >= retry_guard_r) begin
                if (miss_idx < count) begin
                  do_poll    = 1'b1;
                  poll_idx   = miss_idx;
                  poll_retry = 1'b1;
                end else begin
                  do_end = 1'b1;
                end
              end else begin
                wait_timer_nxt = wt_inc;
              end
            end
            default: ;
          endcase
        end
        pmdr_pkg::REQ_TX: begin
          if (phase_r == pmdr_pkg::PH_WAIT_TX) begin
            if (tx_ok) begin
              phase_nxt      = pmdr_pkg::PH_WAIT_RESP;
              wait_timer_nxt = 16'd0;
            end else begin
              do_fail   = 1'b1;
              fail_code = pmdr_pkg::OUT_TX_FAIL;
            end
          end
        end
        pmdr_pkg::REQ_PKT: begin
          if (!pkt_format_ok) begin
            res.packet_status = pmdr_pkg::PST_MALFORMED;
          end else if (!pkt_known || ({1'b0, pkt_node} >= count)) begin
            res.packet_status = pmdr_pkg::PST_UNKNOWN;
          end else if ((pkt_kind == 2'd0) || (pkt_kind != exp_kind)) begin
            res.packet_status = pmdr_pkg::PST_MALFORMED;
          end else begin
            seen_nxt[node_idx] = 1'b1;
            seq_we             = 1'b1;
            res.action         = pmdr_pkg::ACT_ACK;
            res.target_node    = pkt_node;
            res.ack_seq        = pkt_seq;
            res.packet_status  = dup ? pmdr_pkg::PST_DUP : pmdr_pkg::PST_NEW;
            // Only the node being polled, while its answer is awaited, counts
            // as answering the poll.
            if ((phase_r == pmdr_pkg::PH_WAIT_RESP) && (pkt_node == current_index_r)) begin
              phase_nxt        = pmdr_pkg::PH_GUARD;
              wait_timer_nxt   = 16'd0;
              res.poll_outcome = pmdr_pkg::OUT_ANSWERED;
            end
          end
        end
        default: ;
      endcase

      if (do_fail) begin
        // Failures of the retry pass leave the missed map as it is.
        if (!retry_pass_r) begin
          for (int i = 0; i < MAX_NODES; i++) begin
            if (current_index_r == 3'(i)) begin
              missed_map_nxt[i] = 1'b1;
            end
          end
        end
        phase_nxt        = pmdr_pkg::PH_GUARD;
        wait_timer_nxt   = 16'd0;
        res.poll_outcome = fail_code;
      end

      if (do_poll) begin
        current_index_nxt = poll_idx[2:0];
        phase_nxt         = pmdr_pkg::PH_WAIT_TX;
        res.action        = pmdr_pkg::ACT_POLL;
        res.target_node   = poll_idx[2:0];
        res.is_retry      = poll_retry;
      end

      if (do_end) begin
        phase_nxt         = pmdr_pkg::PH_IDLE;
        retry_pass_nxt    = 1'b0;
        missed_map_nxt    = '0;
        current_index_nxt = 3'd0;
        wait_timer_nxt    = 16'd0;
        // An overrun round restarts the interval from its end.
        if (round_timer_nxt >= round_interval_r) begin
          round_timer_nxt = 16'd0;
        end
        res.round_done = 1'b1;
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= pmdr_pkg::PH_IDLE;
      current_index_r <= 3'd0;
      retry_pass_r    <= 1'b0;
      missed_map_r    <= '0;
      wait_timer_r    <= 16'd0;
      round_timer_r   <= 16'd0;
      first_pending_r <= 1'b1;
      seen_r          <= '0;
    end else begin
      phase_r         <= phase_nxt;
      current_index_r <= current_index_nxt;
      retry_pass_r    <= retry_pass_nxt;
      missed_map_r    <= missed_map_nxt;
      wait_timer_r    <= wait_timer_nxt;
      round_timer_r   <= round_timer_nxt;
      first_pending_r <= first_pending_nxt;
      seen_r          <= seen_nxt;
    end
  end

  // Sequence store, written once per acknowledged packet.
  always_ff @(posedge clk) begin
    if (seq_we) begin
      last_seq_r[node_idx] <= pkt_seq;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res_r <= res;
    end
  end

  // Between rounds no retry bookkeeping may survive.
  `PMDR_ASSERT(a_idle_clean, (phase_r != pmdr_pkg::PH_IDLE) || ((missed_map_r == '0) && !retry_pass_r), "idle phase with retry state left over")

  // The polled index never leaves the node capacity.
  `PMDR_ASSERT(a_index_range, {1'b0, current_index_r} < 4'(MAX_NODES), "current node index beyond capacity")

  // Only polls can be marked as retries.
  `PMDR_ASSERT(a_retry_only_poll, !out_valid_r || !out_res_r.is_retry || (out_res_r.action == pmdr_pkg::ACT_POLL), "retry flag on a result that is not a poll")

  // An acknowledgement always reports a new or duplicate packet.
  `PMDR_ASSERT(a_ack_status, !out_valid_r || (out_res_r.action != pmdr_pkg::ACT_ACK) || (out_res_r.packet_status == pmdr_pkg::PST_NEW) || (out_res_r.packet_status == pmdr_pkg::PST_DUP), "acknowledgement without a valid packet status")

  // A transmit result in the wait for one always moves the poll forward.
  `PMDR_ASSERT_NEXT(a_tx_advances, in_accept && (req_type == pmdr_pkg::REQ_TX) && (phase_r == pmdr_pkg::PH_WAIT_TX), (phase_r == pmdr_pkg::PH_WAIT_RESP) || (phase_r == pmdr_pkg::PH_GUARD), "transmit result did not leave the transmit wait")

endmodule
